[sv/utf32_to_utf16_transcoder_top_macros.svh]
// assertion macros used by the transcoder top
`ifndef UTF32_TO_UTF16_TRANSCODER_TOP_MACROS_SVH
`define UTF32_TO_UTF16_TRANSCODER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define U32U16_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("transcoder check failed");

// next-cycle implication, disabled while reset is low
`define U32U16_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("transcoder check failed");

`endif

[sv/u32u16_pkg.sv]
package u32u16_pkg;

    // code points per item and unit slots per result
    localparam int LANES      = 4;
    localparam int UNIT_SLOTS = 2 * LANES;

    // status codes of a result
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SURROGATE = 2'd1,
        ST_RANGE     = 2'd2
    } t_status;

    // configuration register indexes
    localparam logic [2:0] REG_UNIT_ORDER = 3'd0;

    // code point constants
    localparam logic [31:0] CP_MAX       = 32'h0010_FFFF;
    localparam logic [20:0] CP_SUPP_BASE = 21'h01_0000;
    localparam logic [15:0] HI_SURR_BASE = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

    // one classified item, passed from front to back
    typedef struct packed {
        logic [LANES-1:0][15:0] hi;
        logic [LANES-1:0][15:0] lo;
        logic [LANES-1:0]       en;
        logic [LANES-1:0]       wide;
        t_status                status;
        logic [31:0]            err_pos;
    } t_entry;

endpackage

[sv/utf32_to_utf16_transcoder_top.sv]
// UTF-32 to UTF-16 transcoder. Each input item carries up to four code points
// and yields one result of up to eight UTF-16 units, packed from slot 0, with
// status and error position. One item is accepted every clock cycle while the
// result side keeps up; the front classifies an item and updates the stream
// position in the cycle it is accepted. The entry is written into the queue, and
// the back later loads the queue head into the output register and offers it.
// A two-entry queue between front and back lets either side stall alone. A bad
// code point makes the error sticky: later items give no units and repeat the
// error until stream_start.
// Register 0 at byte address 0 (bit 0) selects big-endian unit byte order.
`include "utf32_to_utf16_transcoder_top_macros.svh"

module utf32_to_utf16_transcoder_top #(
    parameter int POSITION_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_code_point_0,
    input  logic [31:0] i_code_point_1,
    input  logic [31:0] i_code_point_2,
    input  logic [31:0] i_code_point_3,
    input  logic [2:0]  i_lanes_used,
    input  logic        i_stream_start,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_unit_0,
    output logic [15:0] o_unit_1,
    output logic [15:0] o_unit_2,
    output logic [15:0] o_unit_3,
    output logic [15:0] o_unit_4,
    output logic [15:0] o_unit_5,
    output logic [15:0] o_unit_6,
    output logic [15:0] o_unit_7,
    output logic [3:0]  o_unit_count,
    output logic [1:0]  o_status,
    output logic [31:0] o_error_position,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import u32u16_pkg::*;

    logic                        r_swap_bytes;
    logic                        cfg_write;
    logic [LANES-1:0][31:0]      code_points;
    logic                        push;
    logic                        full;
    logic                        q_valid;
    logic                        pop;
    t_entry                      push_entry;
    t_entry                      head_entry;
    logic [UNIT_SLOTS-1:0][15:0] units;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr == REG_UNIT_ORDER) ? {31'd0, r_swap_bytes} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap_bytes <= 1'b0;
        end else if (cfg_write && (paddr == REG_UNIT_ORDER)) begin
            r_swap_bytes <= pwdata[0];
        end
    end

    assign code_points = {i_code_point_3, i_code_point_2, i_code_point_1, i_code_point_0};

    // accept and classify
    u32u16_front #(
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_code_point  (code_points),
        .i_lanes_used  (i_lanes_used),
        .i_stream_start(i_stream_start),
        .o_push        (push),
        .o_entry       (push_entry),
        .i_full        (full)
    );

    // decoupling queue
    u32u16_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_entry(push_entry),
        .o_full (full),
        .i_pop  (pop),
        .o_valid(q_valid),
        .o_entry(head_entry)
    );

    // pack units and hold the result
    u32u16_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_swap_bytes    (r_swap_bytes),
        .i_valid         (q_valid),
        .i_entry         (head_entry),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_units         (units),
        .o_unit_count    (o_unit_count),
        .o_status        (o_status),
        .o_error_position(o_error_position)
    );

    assign o_unit_0 = units[0];
    assign o_unit_1 = units[1];
    assign o_unit_2 = units[2];
    assign o_unit_3 = units[3];
    assign o_unit_4 = units[4];
    assign o_unit_5 = units[5];
    assign o_unit_6 = units[6];
    assign o_unit_7 = units[7];

    // checks
    `U32U16_ASSERT_SAME(a_ok_no_position, o_valid && (o_status == ST_OK),
                        o_error_position == 32'd0)
    `U32U16_ASSERT_SAME(a_empty_slot_zero, o_valid && (o_unit_count == 4'd0),
                        o_unit_0 == 16'd0)
    `U32U16_ASSERT_NEXT(a_cfg_written, cfg_write && (paddr == REG_UNIT_ORDER),
                        r_swap_bytes == $past(pwdata[0]))

endmodule

[sv/u32u16_front.sv]
module u32u16_front #(
    parameter int POSITION_BITS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [u32u16_pkg::LANES-1:0][31:0]    i_code_point,
    input  logic [2:0]                            i_lanes_used,
    input  logic                                  i_stream_start,
    output logic                                  o_push,
    output u32u16_pkg::t_entry                    o_entry,
    input  logic                                  i_full
);
    import u32u16_pkg::*;

    logic [POSITION_BITS-1:0] r_pos, n_pos;
    t_status                  r_err, n_err;
    logic [POSITION_BITS-1:0] r_idx, n_idx;

    logic [POSITION_BITS-1:0] cur_pos;
    t_status                  cur_err;
    logic [POSITION_BITS-1:0] cur_idx;
    logic [2:0]               lanes_sat;
    logic [LANES-1:0]         is_wide;
    logic [LANES-1:0]         is_bad;
    logic [LANES-1:0][19:0]   supp;
    logic                     found;
    logic [2:0]               k;
    t_status                  kind;
    logic                     accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept;

    // stream state as seen by this item
    always_comb begin
        cur_pos = i_stream_start ? '0 : r_pos;
        cur_err = i_stream_start ? ST_OK : r_err;
        cur_idx = i_stream_start ? '0 : r_idx;
        lanes_sat = (i_lanes_used > 3'(LANES)) ? 3'(LANES) : i_lanes_used;
    end

    // per-lane classification and surrogate split
    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            is_wide[j] = |i_code_point[j][31:16];
            is_bad[j]  = is_wide[j] ? (i_code_point[j] > CP_MAX)
                                    : (i_code_point[j][15:11] == 5'b11011);
            supp[j]    = 20'(i_code_point[j][20:0] - CP_SUPP_BASE);
        end
    end

    // first bad lane among the used ones
    always_comb begin
        found = 1'b0;
        k     = lanes_sat;
        kind  = ST_OK;
        for (int j = 0; j < LANES; j++) begin
            if (!found && (3'(j) < lanes_sat) && is_bad[j]) begin
                found = 1'b1;
                k     = 3'(j);
                kind  = is_wide[j] ? ST_RANGE : ST_SURROGATE;
            end
        end
    end

    // entry contents and next stream state
    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            o_entry.hi[j]   = is_wide[j] ? (HI_SURR_BASE + 16'(supp[j][19:10]))
                                         : i_code_point[j][15:0];
            o_entry.lo[j]   = LO_SURR_BASE + 16'(supp[j][9:0]);
            o_entry.wide[j] = is_wide[j];
            o_entry.en[j]   = (cur_err == ST_OK) && (3'(j) < k);
        end
        n_pos = cur_pos;
        n_err = cur_err;
        n_idx = cur_idx;
        if (cur_err == ST_OK) begin
            n_pos = cur_pos + POSITION_BITS'(k);
            if (found) begin
                n_err = kind;
                n_idx = cur_pos + POSITION_BITS'(k);
            end
        end
        o_entry.status  = n_err;
        o_entry.err_pos = (n_err == ST_OK) ? 32'd0 : 32'(n_idx);
    end

    // stream state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_err <= ST_OK;
            r_idx <= '0;
        end else if (accept) begin
            r_pos <= n_pos;
            r_err <= n_err;
            r_idx <= n_idx;
        end
    end

endmodule

[sv/u32u16_queue.sv]
module u32u16_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  u32u16_pkg::t_entry i_entry,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output u32u16_pkg::t_entry o_entry
);
    import u32u16_pkg::*;

    t_entry     r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_entry = r_slot[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(do_pop);
        end
    end

endmodule

[sv/u32u16_back.sv]
module u32u16_back (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_swap_bytes,
    input  logic                                      i_valid,
    input  u32u16_pkg::t_entry                        i_entry,
    output logic                                      o_pop,
    output logic                                      o_valid,
    input  logic                                      i_ready,
    output logic [u32u16_pkg::UNIT_SLOTS-1:0][15:0]   o_units,
    output logic [3:0]                                o_unit_count,
    output logic [1:0]                                o_status,
    output logic [31:0]                               o_error_position
);
    import u32u16_pkg::*;

    logic                        r_valid;
    logic [UNIT_SLOTS-1:0][15:0] r_units, n_units;
    logic [3:0]                  r_count, n_count;
    logic [1:0]                  r_status;
    logic [31:0]                 r_err_pos;
    logic                        load;

    assign load  = i_valid && (!r_valid || i_ready);
    assign o_pop = load;

    // pack lane units into slots, swapping bytes if asked
    always_comb begin
        n_units = '0;
        n_count = 4'd0;
        for (int j = 0; j < LANES; j++) begin
            if (i_entry.en[j]) begin
                n_units[n_count[2:0]] = i_swap_bytes
                    ? {i_entry.hi[j][7:0], i_entry.hi[j][15:8]} : i_entry.hi[j];
                if (i_entry.wide[j]) begin
                    n_units[3'(n_count[2:0] + 3'd1)] = i_swap_bytes
                        ? {i_entry.lo[j][7:0], i_entry.lo[j][15:8]} : i_entry.lo[j];
                end
                n_count = n_count + (i_entry.wide[j] ? 4'd2 : 4'd1);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_units   <= n_units;
            r_count   <= n_count;
            r_status  <= i_entry.status;
            r_err_pos <= i_entry.err_pos;
        end
    end

    assign o_valid          = r_valid;
    assign o_units          = r_units;
    assign o_unit_count     = r_count;
    assign o_status         = r_status;
    assign o_error_position = r_err_pos;

endmodule
